// ===== design/vrq_pkg.sv =====
// Shared types and constants for the video RAM update queue.
package vrq_pkg;

   localparam int QUEUE_BYTES_DEFAULT = 192;

   // Request action codes
   localparam logic [2:0] ACT_CLEAR   = 3'd0;
   localparam logic [2:0] ACT_BEGIN   = 3'd1;
   localparam logic [2:0] ACT_PAYLOAD = 3'd2;
   localparam logic [2:0] ACT_FILL    = 3'd3;
   localparam logic [2:0] ACT_VBLANK  = 3'd4;
   localparam logic [2:0] ACT_DRAIN   = 3'd5;

   // Bus access kinds
   localparam logic [1:0] BUS_NONE   = 2'd0;
   localparam logic [1:0] BUS_STATUS = 2'd1;
   localparam logic [1:0] BUS_ADDR   = 2'd2;
   localparam logic [1:0] BUS_DATA   = 2'd3;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] target_address;
      logic [7:0]  record_length;
      logic [7:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic       overflow_flag;
      logic [7:0] bytes_used;
      logic [1:0] bus_kind;
      logic [7:0] bus_byte;
      logic       drain_finished;
      logic [7:0] frame_count;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_item;
      logic       wr_en;
      logic [1:0] wr_k;
      logic       rd_en;
      logic       rd_second;
      logic       hold_capture;
      logic       commit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       wr_needed;
      logic [1:0] wr_last;
      logic       rd_needed;
      logic       rd_two;
      logic       out_free;
   } dp_status_type;

endpackage

// ===== design/vrq_ctrl.sv =====
// Sequencing state machine for the video RAM update queue.
module vrq_ctrl
   import vrq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_WRITE,
      S_READ,
      S_READ_B,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] wr_k_ff, wr_k_in;

   always_comb begin
      state_in = state_ff;
      wr_k_in  = wr_k_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            wr_k_in = 2'd0;
            if (status.wr_needed) begin
               state_in = S_WRITE;
            end else if (status.rd_needed) begin
               state_in = S_READ;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_WRITE: begin
            cmd.wr_en = 1'b1;
            cmd.wr_k  = wr_k_ff;
            if (wr_k_ff == status.wr_last) begin
               state_in = S_FINISH;
            end else begin
               wr_k_in = wr_k_ff + 2'd1;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = status.rd_two ? S_READ_B : S_FINISH;
         end
         S_READ_B: begin
            cmd.rd_en        = 1'b1;
            cmd.rd_second    = 1'b1;
            cmd.hold_capture = 1'b1;
            state_in         = S_FINISH;
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wr_k_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         wr_k_ff  <= wr_k_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== design/vrq_datapath.sv =====
// Queue store, architectural state and result register of the update queue.
module vrq_datapath
   import vrq_pkg::*;
#(
   parameter int QUEUE_BYTES = QUEUE_BYTES_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_payload,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_payload
);

   localparam int AW = $clog2(QUEUE_BYTES);

   localparam logic [1:0] PH_STATUS = 2'd0;
   localparam logic [1:0] PH_ADDR_HI = 2'd1;
   localparam logic [1:0] PH_ADDR_LO = 2'd2;
   localparam logic [1:0] PH_DATA = 2'd3;

   logic [7:0] store_mem [QUEUE_BYTES];
   logic [7:0] rd_q_ff;
   logic [7:0] hold_ff;

   req_type    item_ff;

   logic [7:0] used_ff, used_in;
   logic       ovf_ff, ovf_in;
   logic [7:0] frame_ff, frame_in;
   logic [7:0] wi_ff, wi_in;
   logic [6:0] pay_rem_ff, pay_rem_in;
   logic       lit_open_ff, lit_open_in;
   logic       draining_ff, draining_in;
   logic [7:0] ri_ff, ri_in;
   logic [1:0] phase_ff, phase_in;
   logic [6:0] rec_rem_ff, rec_rem_in;
   logic       rec_fill_ff, rec_fill_in;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   // Decode of the held transaction against current state
   logic       is_begin, is_fill, is_payload, is_drain;
   logic [9:0] need, fill_level;
   logic       hdr_ok, pay_ok;

   assign is_begin   = (item_ff.action == ACT_BEGIN);
   assign is_fill    = (item_ff.action == ACT_FILL);
   assign is_payload = (item_ff.action == ACT_PAYLOAD) && lit_open_ff && !draining_ff;
   assign is_drain   = (item_ff.action == ACT_DRAIN) && draining_ff;
   assign need       = is_begin ? ({2'b00, item_ff.record_length} + 10'd3) : 10'd4;
   assign fill_level = {2'b00, used_ff} + need;
   assign hdr_ok     = (is_begin || is_fill) && !draining_ff && !item_ff.record_length[7]
                       && (fill_level <= 10'(QUEUE_BYTES));
   assign pay_ok     = is_payload;

   always_comb begin
      status.wr_needed = hdr_ok || pay_ok;
      status.wr_last   = hdr_ok ? (is_fill ? 2'd3 : 2'd2) : 2'd0;
      status.rd_needed = is_drain && (phase_ff != PH_STATUS);
      status.rd_two    = (phase_ff == PH_ADDR_LO);
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Store port addressing
   logic [7:0] wr_addr, wr_data, rd_addr;

   always_comb begin
      wr_addr = (hdr_ok ? used_ff : wi_ff) + {6'd0, cmd.wr_k};
      wr_data = item_ff.byte_value;
      if (hdr_ok) begin
         case (cmd.wr_k)
            2'd0: wr_data = item_ff.target_address[15:8];
            2'd1: wr_data = item_ff.target_address[7:0];
            2'd2: wr_data = is_fill ? (item_ff.record_length | 8'h80)
                                    : item_ff.record_length;
            default: wr_data = item_ff.byte_value;
         endcase
      end
      rd_addr = ri_ff + {7'd0, status.rd_two} + {7'd0, cmd.rd_second};
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && (wr_addr < 8'(QUEUE_BYTES))) begin
         store_mem[wr_addr[AW-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= store_mem[rd_addr[AW-1:0]];
      end
   end

   // Next architectural state, applied on commit
   logic [8:0] ri_next;
   logic [6:0] rem_next;
   logic       rec_fill_next;
   logic       rec_end;

   always_comb begin
      used_in     = used_ff;
      ovf_in      = ovf_ff;
      frame_in    = frame_ff;
      wi_in       = wi_ff;
      pay_rem_in  = pay_rem_ff;
      lit_open_in = lit_open_ff;
      draining_in = draining_ff;
      ri_in       = ri_ff;
      phase_in    = phase_ff;
      rec_rem_in  = rec_rem_ff;
      rec_fill_in = rec_fill_ff;
      rsp_in      = '0;
      ri_next       = {1'b0, ri_ff};
      rem_next      = rec_rem_ff;
      rec_fill_next = rec_fill_ff;
      rec_end       = 1'b0;

      case (item_ff.action)
         ACT_CLEAR: begin
            used_in     = 8'd0;
            ovf_in      = 1'b0;
            lit_open_in = 1'b0;
            pay_rem_in  = 7'd0;
            draining_in = 1'b0;
            phase_in    = PH_STATUS;
         end
         ACT_BEGIN, ACT_FILL: begin
            if (!draining_ff) begin
               lit_open_in = 1'b0;
               pay_rem_in  = 7'd0;
               if (!hdr_ok) begin
                  ovf_in = 1'b1;
               end else begin
                  rsp_in.accepted = 1'b1;
                  if (is_fill) begin
                     used_in = fill_level[7:0];
                  end else if (item_ff.record_length == 8'd0) begin
                     used_in = used_ff + 8'd3;
                  end else begin
                     wi_in       = used_ff + 8'd3;
                     pay_rem_in  = item_ff.record_length[6:0];
                     lit_open_in = 1'b1;
                  end
               end
            end
         end
         ACT_PAYLOAD: begin
            if (pay_ok) begin
               wi_in      = wi_ff + 8'd1;
               pay_rem_in = pay_rem_ff - 7'd1;
               if (pay_rem_ff == 7'd1) begin
                  used_in     = wi_ff + 8'd1;
                  lit_open_in = 1'b0;
               end
            end
         end
         ACT_VBLANK: begin
            if (!draining_ff) begin
               lit_open_in = 1'b0;
               pay_rem_in  = 7'd0;
               if (used_ff == 8'd0) begin
                  frame_in = frame_ff + 8'd1;
               end else begin
                  draining_in = 1'b1;
                  ri_in       = 8'd0;
                  phase_in    = PH_STATUS;
               end
            end
         end
         ACT_DRAIN: begin
            if (draining_ff) begin
               case (phase_ff)
                  PH_STATUS: begin
                     rsp_in.bus_kind = BUS_STATUS;
                     phase_in        = PH_ADDR_HI;
                  end
                  PH_ADDR_HI: begin
                     rsp_in.bus_kind = BUS_ADDR;
                     rsp_in.bus_byte = rd_q_ff;
                     phase_in        = PH_ADDR_LO;
                  end
                  PH_ADDR_LO: begin
                     // rd_q holds the length byte, hold the address low byte
                     rsp_in.bus_kind = BUS_ADDR;
                     rsp_in.bus_byte = hold_ff;
                     rec_fill_next   = rd_q_ff[7];
                     rem_next        = rd_q_ff[6:0];
                     ri_next         = {1'b0, ri_ff} + 9'd3;
                     phase_in        = PH_DATA;
                     if (rem_next == 7'd0) begin
                        rec_end = 1'b1;
                        if (rec_fill_next) begin
                           ri_next = ri_next + 9'd1;
                        end
                     end
                  end
                  default: begin
                     rsp_in.bus_kind = BUS_DATA;
                     rsp_in.bus_byte = rd_q_ff;
                     if (!rec_fill_ff) begin
                        ri_next = ri_next + 9'd1;
                     end
                     rem_next = rec_rem_ff - 7'd1;
                     if (rem_next == 7'd0) begin
                        rec_end = 1'b1;
                        if (rec_fill_ff) begin
                           ri_next = ri_next + 9'd1;
                        end
                     end
                  end
               endcase
               if (phase_ff == PH_ADDR_LO || phase_ff == PH_DATA) begin
                  rec_fill_in = rec_fill_next;
                  rec_rem_in  = rem_next;
                  ri_in       = ri_next[7:0];
               end
               if (rec_end) begin
                  phase_in = PH_STATUS;
                  if (ri_next >= {1'b0, used_ff}) begin
                     used_in               = 8'd0;
                     draining_in           = 1'b0;
                     frame_in              = frame_ff + 8'd1;
                     rsp_in.drain_finished = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      rsp_in.overflow_flag = ovf_in;
      rsp_in.bytes_used    = used_in;
      rsp_in.frame_count   = frame_in;
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 8'd0;
         ovf_ff       <= 1'b0;
         frame_ff     <= 8'd0;
         wi_ff        <= 8'd0;
         pay_rem_ff   <= 7'd0;
         lit_open_ff  <= 1'b0;
         draining_ff  <= 1'b0;
         ri_ff        <= 8'd0;
         phase_ff     <= PH_STATUS;
         rec_rem_ff   <= 7'd0;
         rec_fill_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            used_ff     <= used_in;
            ovf_ff      <= ovf_in;
            frame_ff    <= frame_in;
            wi_ff       <= wi_in;
            pay_rem_ff  <= pay_rem_in;
            lit_open_ff <= lit_open_in;
            draining_ff <= draining_in;
            ri_ff       <= ri_in;
            phase_ff    <= phase_in;
            rec_rem_ff  <= rec_rem_in;
            rec_fill_ff <= rec_fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_payload;
      end
      if (cmd.hold_capture) begin
         hold_ff <= rd_q_ff;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/video_ram_update_queue_core.sv =====
// Top level of the video RAM update queue: controller plus datapath.
//
// req channel: one transaction per action (clear, literal begin, literal
//   payload byte, fill, vblank start, drain step), taken when req_valid is
//   high and req_stall is low.
// rsp channel: one result transaction per request, in order: accept flag,
//   sticky overflow, byte count, drain-step bus access, drain-finished, frames.
// Sequencing: one request at a time; after decode it makes one store access
//   a cycle (byte store), then commits. Clear, vblank start, a drain
//   status read and any rejected or ignored request access no byte; payload
//   bytes and address-high/data steps one; the address-low step two reads;
//   an accepted literal begin writes three bytes, an accepted fill four.
//   The result is valid the cycle after the request's last internal cycle.
// Reset: synchronous; empties the queue, clears overflow, frame counter and
//   drain state. Store contents are not cleared; only written bytes are read.
// Stall: a result waits in the output register while rsp_stall is high; the
//   next request is still taken and processed, then holds in its final cycle
//   until the output register frees up.
module video_ram_update_queue_core
   import vrq_pkg::*;
#(
   parameter int QUEUE_BYTES = QUEUE_BYTES_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer: walks each transaction through its store accesses.
   vrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Store, queue/drain state and result register.
   vrq_datapath #(
      .QUEUE_BYTES (QUEUE_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Published length never exceeds capacity.
   a_used_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.bytes_used <= 8'(QUEUE_BYTES)))
      else $error("bytes_used beyond queue capacity");

   // The end of a drain is a bus access and leaves the queue empty.
   a_finish_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.drain_finished) |->
         (rsp_payload.bytes_used == 8'd0 && rsp_payload.bus_kind != BUS_NONE))
      else $error("drain finished without emptying the queue");

   // One transaction in flight: taking a request makes the block busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request channel open while a transaction is in progress");

   // A queued request is never also a bus access.
   a_accept_no_bus: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.accepted) |-> (rsp_payload.bus_kind == BUS_NONE))
      else $error("accepted request reported a bus access");

endmodule
